// File: design/uer_pkg.sv
// Shared types and constants for the ultrasonic echo ranger.
// Transaction structs, phase encoding, register indexes and reset values.
// No dependencies.
package uer_pkg;

	localparam int DIST_W    = 21;
	localparam int CFG_IDX_W = 4;
	localparam int CFG_DAT_W = 16;

	localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_SETTLE  = 4'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER = 4'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE  = 4'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SCALE   = 4'd3;

	// Register reset values (scale = 2.8 us * 0.0343 cm/us in Q0.16)
	localparam logic [7:0]  SETTLE_RST  = 8'd3;
	localparam logic [7:0]  TRIGGER_RST = 8'd10;
	localparam logic [7:0]  SAMPLE_RST  = 8'd2;
	localparam logic [15:0] SCALE_RST   = 16'd6294;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_SETTLE,
		PH_TRIG,
		PH_WAIT,
		PH_MEAS
	} phase_t;

	typedef struct packed {
		logic       start_req;
		logic [1:0] sensor_sel;
		logic [2:0] echo_levels;
	} tick_t;

	typedef struct packed {
		logic [2:0]        trigger_lines;
		logic              busy_res;
		logic              done_res;
		logic [DIST_W-1:0] distance_q8;
		logic [15:0]       echo_count_out;
	} result_t;

endpackage

// File: design/uer_scale.sv
// Echo count to distance conversion: count * Q0.16 scale, rounded to Q8 cm, saturated.
// Depends on uer_pkg.
module uer_scale #(
	parameter int COUNT_WIDTH = 16
) (
	input  logic [COUNT_WIDTH-1:0]    count,
	input  logic [15:0]               scale,
	output logic [uer_pkg::DIST_W-1:0] distance
);
	import uer_pkg::*;

	localparam int PW = COUNT_WIDTH + 16;
	localparam int SW = PW - 8;
	localparam int EW = (SW > DIST_W) ? SW : DIST_W;

	logic [PW-1:0] prod;
	logic [PW-1:0] rounded;
	logic [EW-1:0] q8_ext;

	// Product plus half an LSB of Q8, then drop eight fraction bits
	assign prod    = PW'(count) * PW'(scale);
	assign rounded = prod + PW'(128);
	assign q8_ext  = EW'(rounded[PW-1:8]);

	always_comb begin
		if (q8_ext > EW'(DIST_MAX)) begin
			distance = DIST_MAX;
		end else begin
			distance = q8_ext[DIST_W-1:0];
		end
	end

endmodule

// File: design/ultrasonic_echo_ranger_unit.sv
// Ultrasonic echo ranger top level: tick input register, phase FSM, result register.
// Depends on uer_pkg and uer_scale.
//
//  channel | signals                                  | direction | payload
//  tick    | tick_valid, tick_stall, tick_data        | in        | uer_pkg::tick_t
//  result  | result_valid, result_stall, result_data  | out       | uer_pkg::result_t
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data| in        | index + 16-bit value
//
// One tick per clock while tick_stall is low; each tick gives exactly one result via the input
// register, then the result register. The echo-to-distance multiply sits between them.
// Reset clears phase, counters, distance and registers to their defaults; no clearing pass.
// A stalled result holds the result register; the input register keeps accepting until
// it too is full, then tick_stall rises. cfg_ready is always high.
module ultrasonic_echo_ranger_unit #(
	parameter int NUM_SENSORS = 3,
	parameter int COUNT_WIDTH = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      tick_valid,
	output logic                      tick_stall,
	input  uer_pkg::tick_t            tick_data,
	output logic                      result_valid,
	input  logic                      result_stall,
	output uer_pkg::result_t          result_data,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [uer_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [uer_pkg::CFG_DAT_W-1:0] cfg_data
);
	import uer_pkg::*;

	localparam logic [3:0] NUM_SEN_L = 4'(NUM_SENSORS);
	localparam int         CEW       = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;

	// Configuration registers
	logic [7:0]  settle_q, trigger_q, sample_q;
	logic [15:0] scale_q;

	// Pipeline and result registers
	tick_t   tick_s1;
	logic    valid_s1;
	result_t result_q;
	logic    result_valid_q;
	logic    step;

	// FSM state
	phase_t                 phase_q, phase_d;
	logic [1:0]             active_q, active_d;
	logic [7:0]             timer_q, timer_d;
	logic [COUNT_WIDTH-1:0] count_q, count_d;
	logic [DIST_W-1:0]      dist_q, dist_d;
	logic                   done_d;
	logic                   echo_hi;
	logic [3:0]             echo_pad;
	logic [DIST_W-1:0]      dist_calc;
	logic [3:0]             trig_onehot;
	logic [CEW-1:0]         count_ext;

	assign cfg_ready = 1'b1;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			settle_q  <= SETTLE_RST;
			trigger_q <= TRIGGER_RST;
			sample_q  <= SAMPLE_RST;
			scale_q   <= SCALE_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_SETTLE:  settle_q  <= cfg_data[7:0];
				CFG_TRIGGER: trigger_q <= cfg_data[7:0];
				CFG_SAMPLE:  sample_q  <= cfg_data[7:0];
				CFG_SCALE:   scale_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// Handshake: the tick moves on whenever the result register is free or draining
	assign step       = valid_s1 && !(result_valid_q && result_stall);
	assign tick_stall = valid_s1 && result_valid_q && result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (tick_valid && !tick_stall) begin
			valid_s1 <= 1'b1;
		end else if (step) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (tick_valid && !tick_stall) begin
			tick_s1 <= tick_data;
		end
	end

	// Distance of the current count
	uer_scale #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_scale (
		.count(count_q),
		.scale(scale_q),
		.distance(dist_calc)
	);

	// Echo of the active sensor; a sensor beyond the three pins reads low
	assign echo_pad = {1'b0, tick_s1.echo_levels};
	assign echo_hi  = echo_pad[active_q];

	// Next state
	always_comb begin
		phase_d  = phase_q;
		active_d = active_q;
		timer_d  = timer_q;
		count_d  = count_q;
		dist_d   = dist_q;
		done_d   = 1'b0;
		case (phase_q)
			PH_IDLE: begin
				if (tick_s1.start_req) begin
					active_d = tick_s1.sensor_sel;
					if ({2'b00, tick_s1.sensor_sel} >= NUM_SEN_L) begin
						count_d = '0;
						dist_d  = '0;
						done_d  = 1'b1;
					end else begin
						phase_d = PH_SETTLE;
						timer_d = 8'd1;
					end
				end
			end
			PH_SETTLE: begin
				if (timer_q >= settle_q) begin
					phase_d = PH_TRIG;
					timer_d = 8'd1;
				end else begin
					timer_d = timer_q + 8'd1;
				end
			end
			PH_TRIG: begin
				if (timer_q >= trigger_q) begin
					phase_d = PH_WAIT;
					timer_d = 8'd0;
				end else begin
					timer_d = timer_q + 8'd1;
				end
			end
			PH_WAIT: begin
				if (echo_hi) begin
					count_d = COUNT_WIDTH'(1);
					timer_d = 8'd1;
					phase_d = PH_MEAS;
				end
			end
			PH_MEAS: begin
				if (timer_q < sample_q) begin
					timer_d = timer_q + 8'd1;
				end else if (echo_hi) begin
					if (count_q != {COUNT_WIDTH{1'b1}}) begin
						count_d = count_q + COUNT_WIDTH'(1);
					end
					timer_d = 8'd1;
				end else begin
					dist_d  = dist_calc;
					phase_d = PH_IDLE;
					timer_d = 8'd0;
					done_d  = 1'b1;
				end
			end
			default: begin
				phase_d = PH_IDLE;
				timer_d = 8'd0;
			end
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			active_q <= 2'd0;
			timer_q  <= 8'd0;
			count_q  <= '0;
			dist_q   <= '0;
		end else if (step) begin
			phase_q  <= phase_d;
			active_q <= active_d;
			timer_q  <= timer_d;
			count_q  <= count_d;
			dist_q   <= dist_d;
		end
	end

	// Result fields from the updated state
	assign trig_onehot = 4'd1 << active_d;
	assign count_ext   = CEW'(count_d);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (step) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			result_q.trigger_lines  <= (phase_d == PH_TRIG) ? trig_onehot[2:0] : 3'd0;
			result_q.busy_res       <= (phase_d != PH_IDLE);
			result_q.done_res       <= done_d;
			result_q.distance_q8    <= dist_d;
			result_q.echo_count_out <= count_ext[15:0];
		end
	end

	assign result_valid = result_valid_q;
	assign result_data  = result_q;

	// Checks
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q && result_q.done_res |-> !result_q.busy_res)
		else $error("done reported while still busy");

	a_trig_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q && (result_q.trigger_lines != 3'd0)
		|-> result_q.busy_res && $onehot(result_q.trigger_lines))
		else $error("trigger lines driven outside a measurement");

	a_active_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q != PH_IDLE) |-> ({2'b00, active_q} < NUM_SEN_L))
		else $error("measurement running on an invalid sensor");

	a_step_result: assert property (@(posedge clk) disable iff (!arst_n)
		step |=> result_valid_q)
		else $error("processed tick produced no result");

endmodule
